FILE: src/tevq_pkg.sv
// Shared types, constants and helpers for the timed event queue.
package tevq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int TIME_W    = 48;

  typedef enum logic [3:0] {
    OP_POST,
    OP_REL_ALL,
    OP_REL_OWN,
    OP_CAN_OWN,
    OP_CAN_NUM,
    OP_CAN_FLAG,
    OP_QUERY,
    OP_PP_NUM,
    OP_PP_OWN,
    OP_CLEAR,
    OP_NOP
  } op_t;

  localparam logic [3:0] REQ_POST     = 4'd0;
  localparam logic [3:0] REQ_REL_ALL  = 4'd1;
  localparam logic [3:0] REQ_REL_OWN  = 4'd2;
  localparam logic [3:0] REQ_CAN_OWN  = 4'd3;
  localparam logic [3:0] REQ_CAN_NUM  = 4'd4;
  localparam logic [3:0] REQ_CAN_FLAG = 4'd5;
  localparam logic [3:0] REQ_QUERY    = 4'd6;
  localparam logic [3:0] REQ_PP_NUM   = 4'd7;
  localparam logic [3:0] REQ_PP_OWN   = 4'd8;
  localparam logic [3:0] REQ_CLEAR    = 4'd9;

  typedef struct packed {
    op_t                op;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  tpost;
    logic [31:0]        delay;
    logic [7:0]         owner_id;
    logic [15:0]        event_num;
    logic [15:0]        event_handle;
    logic [31:0]        flags;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0]  due_time;
    logic [7:0]         owner;
    logic [15:0]        num;
    logic [15:0]        handle;
    logic [31:0]        flags;
  } entry_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] handle;
    logic [15:0] num;
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PP_ADD,
    ST_INS,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DROP,
    ACT_INS
  } act_t;

  // Saturating time addition; the result never exceeds the largest 48-bit time.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [31:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W-31){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

FILE: src/tevq_front.sv
// Front end: accepts requests, decodes the type, precomputes the post time, queues them.
module tevq_front
  import tevq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic [47:0] in_now,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_event_num,
  input  logic [15:0] in_event_handle,
  input  logic [31:0] in_flags,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_pop
);

  req_t        q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  op_t         op_dec;
  req_t        new_req;

  always_comb begin
    unique case (in_req_type)
      REQ_POST:     op_dec = OP_POST;
      REQ_REL_ALL:  op_dec = OP_REL_ALL;
      REQ_REL_OWN:  op_dec = OP_REL_OWN;
      REQ_CAN_OWN:  op_dec = OP_CAN_OWN;
      REQ_CAN_NUM:  op_dec = OP_CAN_NUM;
      REQ_CAN_FLAG: op_dec = OP_CAN_FLAG;
      REQ_QUERY:    op_dec = OP_QUERY;
      REQ_PP_NUM:   op_dec = OP_PP_NUM;
      REQ_PP_OWN:   op_dec = OP_PP_OWN;
      REQ_CLEAR:    op_dec = OP_CLEAR;
      default:      op_dec = OP_NOP;
    endcase
  end

  always_comb begin
    new_req.op           = op_dec;
    new_req.now          = in_now;
    new_req.tpost        = sat_add(in_now, in_delay);
    new_req.delay        = in_delay;
    new_req.owner_id     = in_owner_id;
    new_req.event_num    = in_event_num;
    new_req.event_handle = in_event_handle;
    new_req.flags        = in_flags;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = req_pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, req_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

FILE: src/tevq_back.sv
// Back end: sorted event table, scan and insert engine, released-event buffer and output stage.
module tevq_back
  import tevq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_event,
  output logic [7:0]  out_owner,
  output logic [15:0] out_handle,
  output logic [15:0] out_num,
  output logic        out_answer,
  output logic [5:0]  out_pending_count,
  output logic        out_status,
  output logic        out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   rd_r, rd_nxt;
  logic            ans_r, ans_nxt;
  logic            st_r, st_nxt;
  req_t            cur_r, cur_nxt;
  entry_t          ins_r, ins_nxt;

  entry_t          slot_r [DEPTH];
  ev_t             ev_mem [DEPTH];
  ev_t             evq_r;

  act_t            act;
  logic            push;
  logic [DEPTH-1:0] le;

  entry_t          e;
  logic            valid_i, due, own_hit, num_hit, flag_hit, last_res;

  logic            ov_r, ov_nxt;
  logic            o_has_r, o_has_nxt;
  ev_t             o_ev_r, o_ev_nxt;
  logic            o_ans_r, o_ans_nxt;
  logic [5:0]      o_cnt_r, o_cnt_nxt;
  logic            o_st_r, o_st_nxt;
  logic            o_last_r, o_last_nxt;

  assign e        = slot_r[i_r[IW-1:0]];
  assign valid_i  = (i_r < fill_r);
  assign due      = (e.due_time <= cur_r.now);
  assign own_hit  = (e.owner == cur_r.owner_id);
  assign num_hit  = (e.num == cur_r.event_num);
  assign flag_hit = |(e.flags & cur_r.flags);
  assign last_res = (n_r == '0) || ((rd_r + CW'(1)) == n_r);

  // Entries at or before the insert time form a prefix of the sorted table.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      le[j] = (CW'(j) < fill_r) && (slot_r[j].due_time <= ins_r.due_time);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    rd_nxt     = rd_r;
    ans_nxt    = ans_r;
    st_nxt     = st_r;
    cur_nxt    = cur_r;
    ins_nxt    = ins_r;
    act        = ACT_NONE;
    push       = 1'b0;
    req_pop    = 1'b0;
    ov_nxt     = ov_r && out_stall;
    o_has_nxt  = o_has_r;
    o_ev_nxt   = o_ev_r;
    o_ans_nxt  = o_ans_r;
    o_cnt_nxt  = o_cnt_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          cur_nxt = req;
          i_nxt   = '0;
          n_nxt   = '0;
          rd_nxt  = '0;
          ans_nxt = 1'b0;
          st_nxt  = 1'b0;
          case (req.op)
            OP_POST: begin
              if (fill_r == CW'(DEPTH)) begin
                st_nxt    = 1'b1;
                state_nxt = ST_EMIT_RD;
              end else begin
                ins_nxt.due_time = req.tpost;
                ins_nxt.owner    = req.owner_id;
                ins_nxt.num      = req.event_num;
                ins_nxt.handle   = req.event_handle;
                ins_nxt.flags    = req.flags;
                state_nxt        = ST_INS;
              end
            end
            OP_CLEAR: begin
              fill_nxt  = '0;
              state_nxt = ST_EMIT_RD;
            end
            OP_NOP: state_nxt = ST_EMIT_RD;
            default: state_nxt = ST_SCAN;
          endcase
        end
      end

      ST_SCAN: begin
        if (!valid_i) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          case (cur_r.op)
            OP_REL_ALL: begin
              if (due) begin
                push     = 1'b1;
                n_nxt    = n_r + CW'(1);
                act      = ACT_DROP;
                fill_nxt = fill_r - CW'(1);
              end else begin
                state_nxt = ST_EMIT_RD;
              end
            end
            OP_REL_OWN: begin
              if (!due) begin
                state_nxt = ST_EMIT_RD;
              end else if (own_hit) begin
                push     = 1'b1;
                n_nxt    = n_r + CW'(1);
                act      = ACT_DROP;
                fill_nxt = fill_r - CW'(1);
                ans_nxt  = 1'b1;
              end else begin
                i_nxt = i_r + CW'(1);
              end
            end
            OP_CAN_OWN, OP_CAN_NUM, OP_CAN_FLAG: begin
              if (own_hit && (cur_r.op == OP_CAN_OWN ||
                              (cur_r.op == OP_CAN_NUM && num_hit) ||
                              (cur_r.op == OP_CAN_FLAG && flag_hit))) begin
                act      = ACT_DROP;
                fill_nxt = fill_r - CW'(1);
              end else begin
                i_nxt = i_r + CW'(1);
              end
            end
            OP_QUERY: begin
              if (own_hit && num_hit) begin
                ans_nxt   = 1'b1;
                state_nxt = ST_EMIT_RD;
              end else begin
                i_nxt = i_r + CW'(1);
              end
            end
            OP_PP_NUM, OP_PP_OWN: begin
              if (own_hit && (cur_r.op == OP_PP_OWN || num_hit)) begin
                ins_nxt   = e;
                act       = ACT_DROP;
                fill_nxt  = fill_r - CW'(1);
                ans_nxt   = 1'b1;
                state_nxt = ST_PP_ADD;
              end else begin
                i_nxt = i_r + CW'(1);
              end
            end
            default: state_nxt = ST_EMIT_RD;
          endcase
        end
      end

      ST_PP_ADD: begin
        ins_nxt.due_time = sat_add(ins_r.due_time, cur_r.delay);
        state_nxt        = ST_INS;
      end

      ST_INS: begin
        act       = ACT_INS;
        fill_nxt  = fill_r + CW'(1);
        state_nxt = ST_EMIT_RD;
      end

      // The event buffer read is registered, so ST_EMIT_RD waits for the read before ST_EMIT_WR uses it.
      ST_EMIT_RD: state_nxt = ST_EMIT_WR;

      ST_EMIT_WR: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          o_has_nxt  = (n_r != '0);
          o_ev_nxt   = (n_r != '0) ? evq_r : '0;
          o_ans_nxt  = ans_r;
          o_cnt_nxt  = 6'(fill_r);
          o_st_nxt   = st_r;
          o_last_nxt = last_res;
          if (last_res) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_nxt    = rd_r + CW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    rd_r     <= rd_nxt;
    ans_r    <= ans_nxt;
    st_r     <= st_nxt;
    cur_r    <= cur_nxt;
    ins_r    <= ins_nxt;
    o_has_r  <= o_has_nxt;
    o_ev_r   <= o_ev_nxt;
    o_ans_r  <= o_ans_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

  // Table update: a drop closes the gap at the scan index, an insert opens one at the prefix end.
  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      if (act == ACT_DROP) begin
        if ((CW'(j) >= i_r) && (j < DEPTH - 1)) begin
          slot_r[j] <= slot_r[(j + 1) % DEPTH];
        end
      end else if (act == ACT_INS) begin
        if (!le[j] && (j == 0 || le[(j + DEPTH - 1) % DEPTH])) begin
          slot_r[j] <= ins_r;
        end else if ((j > 0) && !le[(j + DEPTH - 1) % DEPTH] && (CW'(j) <= fill_r)) begin
          slot_r[j] <= slot_r[(j + DEPTH - 1) % DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ev_mem[n_r[IW-1:0]] <= '{owner: e.owner, handle: e.handle, num: e.num};
    end
    evq_r <= ev_mem[rd_r[IW-1:0]];
  end

  assign out_valid         = ov_r;
  assign out_has_event     = o_has_r;
  assign out_owner         = o_ev_r.owner;
  assign out_handle        = o_ev_r.handle;
  assign out_num           = o_ev_r.num;
  assign out_answer        = o_ans_r;
  assign out_pending_count = o_cnt_r;
  assign out_status        = o_st_r;
  assign out_last          = o_last_r;

endmodule

FILE: src/timed_event_queue_top.sv
// Flow: a post that fits goes from ST_IDLE through ST_INS to ST_EMIT_RD and ST_EMIT_WR; a
// scan request walks the table in ST_SCAN, then each result goes via ST_EMIT_RD, ST_EMIT_WR.
// Throughput: one request at a time in the back end, set by the single scan index over the
// table and the registered read of the released-event buffer; a 2-deep request queue
// and the output register let both sides keep moving. Reset clears the fill count, the FSM
// state and the output valid flag; table entries stay undefined and need no clearing pass.
module timed_event_queue_top
  import tevq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic [47:0] in_now,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_event_num,
  input  logic [15:0] in_event_handle,
  input  logic [31:0] in_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_event,
  output logic [7:0]  out_owner,
  output logic [15:0] out_handle,
  output logic [15:0] out_num,
  output logic        out_answer,
  output logic [5:0]  out_pending_count,
  output logic        out_status,
  output logic        out_last
);

  logic req_valid;
  logic req_pop;
  req_t req;

  tevq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_now          (in_now),
    .in_delay        (in_delay),
    .in_owner_id     (in_owner_id),
    .in_event_num    (in_event_num),
    .in_event_handle (in_event_handle),
    .in_flags        (in_flags),
    .req_valid       (req_valid),
    .req             (req),
    .req_pop         (req_pop)
  );

  tevq_back #(.DEPTH(DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req               (req),
    .req_pop           (req_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_event     (out_has_event),
    .out_owner         (out_owner),
    .out_handle        (out_handle),
    .out_num           (out_num),
    .out_answer        (out_answer),
    .out_pending_count (out_pending_count),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule
